// File: sv/bkle_pkg.sv
// shared types and constants for the bounded keyed list engine
package bkle_pkg;

   localparam int CAPACITY   = 16;
   localparam int KEY_BITS   = 32;
   localparam int VALUE_BITS = 32;
   localparam int POS_BITS   = 6;
   localparam int CNT_BITS   = 5;
   localparam int IDX_BITS   = $clog2(CAPACITY);

   // position code that asks an insert to append
   localparam logic [POS_BITS-1:0] POS_APPEND = '1;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_REMOVE = 2'd1,
      ACT_UPDATE = 2'd2,
      ACT_READ   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_FULL   = 2'd1,
      STATUS_BADPOS = 2'd2,
      STATUS_NOKEY  = 2'd3
   } status_type;

   typedef struct packed {
      logic load;
      logic exec;
   } dp_cmd_type;

endpackage

// File: sv/bkle_req_if.sv
// request channel interface
interface bkle_req_if;
   import bkle_pkg::*;

   logic                         valid;
   logic                         ready;
   logic        [1:0]            action;
   logic signed [POS_BITS-1:0]   position;
   logic signed [KEY_BITS-1:0]   key;
   logic signed [VALUE_BITS-1:0] value;

   modport source (output valid, action, position, key, value, input ready);
   modport sink   (input valid, action, position, key, value, output ready);
endinterface

// File: sv/bkle_rsp_if.sv
// response channel interface
interface bkle_rsp_if;
   import bkle_pkg::*;

   logic                         valid;
   logic                         ready;
   logic        [1:0]            status;
   logic signed [KEY_BITS-1:0]   key_out;
   logic signed [VALUE_BITS-1:0] value_out;
   logic        [CNT_BITS-1:0]   count;

   modport source (output valid, status, key_out, value_out, count, input ready);
   modport sink   (input valid, status, key_out, value_out, count, output ready);
endinterface

// File: sv/bounded_keyed_list_engine_unit.sv
// top level of the bounded keyed list engine
// an accepted request beat is captured, then the execute step registers its response beat as valid
// no new request is taken while the sequencer is in its execute step
// a new request is taken only with no response waiting, or at the edge the waiting one drains
// reset: synchronous, clears the entry count and the handshake state; entry storage is not cleared
module bounded_keyed_list_engine_unit (
   input  logic       clock,
   input  logic       reset,
   bkle_req_if.sink   req,
   bkle_rsp_if.source rsp
);
   import bkle_pkg::*;

   // command bundle from sequencer to datapath
   dp_cmd_type cmd;

   // sequencer: capture step then execute step, response held until taken
   bkle_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .rsp_valid (rsp.valid),
      .rsp_ready (rsp.ready),
      .cmd       (cmd)
   );

   // datapath: entries shift in parallel, all keys compared at once on update
   bkle_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_action    (req.action),
      .req_position  (req.position),
      .req_key       (req.key),
      .req_value     (req.value),
      .rsp_status    (rsp.status),
      .rsp_key_out   (rsp.key_out),
      .rsp_value_out (rsp.value_out),
      .rsp_count     (rsp.count)
   );

endmodule

// File: sv/bkle_controller.sv
// request sequencing and response handshake control
module bkle_controller (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output bkle_pkg::dp_cmd_type cmd
);
   import bkle_pkg::*;

   typedef enum logic {ST_IDLE, ST_EXEC} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   assign req_ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign cmd.load  = req_valid && req_ready;
   assign cmd.exec  = (state_ff == ST_EXEC);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (cmd.load) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: sv/bkle_datapath.sv
// entry registers, shift network, key match and result register
module bkle_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  bkle_pkg::dp_cmd_type                  cmd,
   input  logic        [1:0]                     req_action,
   input  logic signed [bkle_pkg::POS_BITS-1:0]  req_position,
   input  logic signed [bkle_pkg::KEY_BITS-1:0]  req_key,
   input  logic signed [bkle_pkg::VALUE_BITS-1:0] req_value,
   output logic        [1:0]                     rsp_status,
   output logic signed [bkle_pkg::KEY_BITS-1:0]  rsp_key_out,
   output logic signed [bkle_pkg::VALUE_BITS-1:0] rsp_value_out,
   output logic        [bkle_pkg::CNT_BITS-1:0]  rsp_count
);
   import bkle_pkg::*;

   // captured request
   action_type            act_ff;
   logic [POS_BITS-1:0]   pos_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [VALUE_BITS-1:0] val_ff;

   // list storage
   logic [KEY_BITS-1:0]   keys_ff   [CAPACITY];
   logic [KEY_BITS-1:0]   keys_in   [CAPACITY];
   logic [VALUE_BITS-1:0] vals_ff   [CAPACITY];
   logic [VALUE_BITS-1:0] vals_in   [CAPACITY];
   logic [CNT_BITS-1:0]   count_ff, count_in;

   // result register
   status_type            status_ff, status_in;
   logic [KEY_BITS-1:0]   kout_ff, kout_in;
   logic [VALUE_BITS-1:0] vout_ff, vout_in;
   logic [CNT_BITS-1:0]   cout_ff;

   logic                  pos_ok;
   logic                  full;
   logic [CNT_BITS-1:0]   pos_u;
   logic [CNT_BITS-1:0]   ins_at;
   logic [CAPACITY-1:0]   match;
   logic [CAPACITY-1:0]   first_hit;
   logic [IDX_BITS-1:0]   rd_idx;

   assign pos_u     = pos_ff[CNT_BITS-1:0];
   assign pos_ok    = !pos_ff[POS_BITS-1] && (pos_u < count_ff);
   assign full      = (count_ff == CNT_BITS'(CAPACITY));
   assign ins_at    = pos_ok ? pos_u : count_ff;
   assign rd_idx    = pos_ff[IDX_BITS-1:0];
   // lowest set bit of the match vector
   assign first_hit = match & (~match + CAPACITY'(1));

   always_comb begin
      for (int i = 0; i < CAPACITY; i++) begin
         match[i] = (CNT_BITS'(i) < count_ff) && (keys_ff[i] == key_ff);
      end
   end

   always_comb begin
      keys_in   = keys_ff;
      vals_in   = vals_ff;
      count_in  = count_ff;
      status_in = STATUS_OK;
      kout_in   = '0;
      vout_in   = '0;
      case (act_ff)
         ACT_INSERT: begin
            if (full) begin
               status_in = STATUS_FULL;
            end else if (pos_ff[POS_BITS-1] && (pos_ff != POS_APPEND)) begin
               status_in = STATUS_BADPOS;
            end else begin
               // entries from the insert point up move one place higher
               for (int i = 1; i < CAPACITY; i++) begin
                  if ((CNT_BITS'(i) > ins_at) && (CNT_BITS'(i) <= count_ff)) begin
                     keys_in[i] = keys_ff[i-1];
                     vals_in[i] = vals_ff[i-1];
                  end
               end
               for (int i = 0; i < CAPACITY; i++) begin
                  if (CNT_BITS'(i) == ins_at) begin
                     keys_in[i] = key_ff;
                     vals_in[i] = val_ff;
                  end
               end
               count_in = count_ff + CNT_BITS'(1);
               kout_in  = key_ff;
               vout_in  = val_ff;
            end
         end
         ACT_REMOVE: begin
            if (!pos_ok) begin
               status_in = STATUS_BADPOS;
            end else begin
               kout_in = keys_ff[rd_idx];
               vout_in = vals_ff[rd_idx];
               // close the gap
               for (int i = 0; i < CAPACITY - 1; i++) begin
                  if ((CNT_BITS'(i) >= pos_u) && (CNT_BITS'(i + 1) < count_ff)) begin
                     keys_in[i] = keys_ff[i+1];
                     vals_in[i] = vals_ff[i+1];
                  end
               end
               count_in = count_ff - CNT_BITS'(1);
            end
         end
         ACT_UPDATE: begin
            if (|match) begin
               for (int i = 0; i < CAPACITY; i++) begin
                  if (first_hit[i]) begin
                     vals_in[i] = val_ff;
                  end
               end
               kout_in = key_ff;
               vout_in = val_ff;
            end else begin
               status_in = STATUS_NOKEY;
            end
         end
         default: begin
            if (!pos_ok) begin
               status_in = STATUS_BADPOS;
            end else begin
               kout_in = keys_ff[rd_idx];
               vout_in = vals_ff[rd_idx];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= action_type'(req_action);
         pos_ff <= req_position;
         key_ff <= req_key;
         val_ff <= req_value;
      end
      if (cmd.exec) begin
         keys_ff   <= keys_in;
         vals_ff   <= vals_in;
         status_ff <= status_in;
         kout_ff   <= kout_in;
         vout_ff   <= vout_in;
         cout_ff   <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   assign rsp_status    = status_ff;
   assign rsp_key_out   = kout_ff;
   assign rsp_value_out = vout_ff;
   assign rsp_count     = cout_ff;

endmodule

// File: sim/tb_bounded_keyed_list_engine_unit.sv
// self-checking testbench for the bounded keyed list engine: random and directed requests
`timescale 1ns / 100ps

module tb_bounded_keyed_list_engine_unit;
   import bkle_pkg::*;

   // run shape
   localparam int RANDOM_ITEMS  = 1100;
   localparam int TAIL_ITEMS    = 150;   // last beats run with no idling
   localparam int PRESSURE_AT   = 300;   // request beats taken before the long hold
   localparam int HOLD_CYCLES   = 400;   // length of the long response hold
   localparam int PHASE_ITEMS   = 60;    // random items per fill or drain phase
   localparam int POOL_SIZE     = 8;
   localparam int DRAIN_CYCLES  = 8;
   localparam int MAX_REPORTS   = 10;

   typedef struct {
      action_type                   act;
      logic signed [POS_BITS-1:0]   pos;
      logic signed [KEY_BITS-1:0]   key;
      logic signed [VALUE_BITS-1:0] value;
   } list_req_type;

   typedef struct {
      status_type                   status;
      logic signed [KEY_BITS-1:0]   key;
      logic signed [VALUE_BITS-1:0] value;
      logic        [CNT_BITS-1:0]   count;
   } list_outcome_type;

   logic clock = 1'b0;
   logic reset;

   bkle_req_if req_ch ();
   bkle_rsp_if rsp_ch ();

   bounded_keyed_list_engine_unit dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // requests waiting to be driven, and outcomes waiting to come back
   list_req_type     pending_reqs[$];
   list_outcome_type list_outcomes[$];

   // shadow copy of the list, advanced at each accepted request beat
   logic signed [KEY_BITS-1:0]   shadow_keys [CAPACITY];
   logic signed [VALUE_BITS-1:0] shadow_vals [CAPACITY];
   int                           shadow_count = 0;

   // rough count tracked while generating, to aim positions inside the list
   int                           gen_count = 0;
   logic signed [KEY_BITS-1:0]   key_pool [POOL_SIZE];

   int   total_items = 0;
   int   tail_start  = 1 << 30;
   int   beats_in    = 0;
   int   fail_count  = 0;
   bit   req_fire    = 1'b0;
   int   req_gap     = 0;
   int   rsp_stall   = 0;
   int   hold_left   = 0;
   bit   hold_done   = 1'b0;

   // next list state and the response it gives for one request
   function automatic list_outcome_type list_op_outcome(action_type act,
                                                     logic signed [POS_BITS-1:0] pos,
                                                     logic signed [KEY_BITS-1:0] k,
                                                     logic signed [VALUE_BITS-1:0] v);
      list_outcome_type o;
      int p;
      int at;
      int i;
      o.status = STATUS_OK;
      o.key    = '0;
      o.value  = '0;
      p        = pos;
      case (act)
         ACT_INSERT: begin
            if (shadow_count >= CAPACITY) begin
               o.status = STATUS_FULL;
            end else if (p < -1) begin
               o.status = STATUS_BADPOS;
            end else begin
               // -1 or anything at or past the end appends
               at = (p >= 0 && p < shadow_count) ? p : shadow_count;
               for (i = shadow_count; i > at; i--) begin
                  shadow_keys[i] = shadow_keys[i-1];
                  shadow_vals[i] = shadow_vals[i-1];
               end
               shadow_keys[at] = k;
               shadow_vals[at] = v;
               shadow_count++;
               o.key   = k;
               o.value = v;
            end
         end
         ACT_REMOVE: begin
            if (p < 0 || p >= shadow_count) begin
               o.status = STATUS_BADPOS;
            end else begin
               o.key   = shadow_keys[p];
               o.value = shadow_vals[p];
               for (i = p; i + 1 < shadow_count; i++) begin
                  shadow_keys[i] = shadow_keys[i+1];
                  shadow_vals[i] = shadow_vals[i+1];
               end
               shadow_count--;
            end
         end
         ACT_UPDATE: begin
            // only the first matching key is touched
            o.status = STATUS_NOKEY;
            for (i = 0; i < shadow_count; i++) begin
               if (o.status == STATUS_NOKEY && shadow_keys[i] == k) begin
                  shadow_vals[i] = v;
                  o.key    = k;
                  o.value  = v;
                  o.status = STATUS_OK;
               end
            end
         end
         default: begin
            if (p < 0 || p >= shadow_count) begin
               o.status = STATUS_BADPOS;
            end else begin
               o.key   = shadow_keys[p];
               o.value = shadow_vals[p];
            end
         end
      endcase
      o.count = shadow_count[CNT_BITS-1:0];
      return o;
   endfunction

   // queue one request and keep the generation-time count in step
   function automatic void push_req(action_type act, logic signed [POS_BITS-1:0] pos,
                                    logic signed [KEY_BITS-1:0] k,
                                    logic signed [VALUE_BITS-1:0] v);
      list_req_type r;
      int p;
      p       = pos;
      r.act   = act;
      r.pos   = pos;
      r.key   = k;
      r.value = v;
      pending_reqs = {pending_reqs, r};
      if (act == ACT_INSERT && gen_count < CAPACITY && p >= -1) begin
         gen_count++;
         key_pool[$urandom_range(0, POOL_SIZE-1)] = k;
      end else if (act == ACT_REMOVE && p >= 0 && p < gen_count) begin
         gen_count--;
      end
   endfunction

   function automatic logic signed [KEY_BITS-1:0] pick_key();
      case ($urandom_range(0, 15))
         0:       return {1'b1, {(KEY_BITS-1){1'b0}}};
         1:       return {1'b0, {(KEY_BITS-1){1'b1}}};
         2:       return '0;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [POS_BITS-1:0] pick_pos(action_type act);
      int r;
      int hi;
      r  = $urandom_range(0, 9);
      hi = (act == ACT_INSERT) ? gen_count : gen_count - 1;
      if (r < 7)
         return (hi < 0) ? '0 : POS_BITS'($urandom_range(0, hi));
      else if (r == 7)
         return POS_APPEND;
      else
         return POS_BITS'($urandom);
   endfunction

   // stimulus and end of run
   initial begin
      action_type act;
      int         w;
      bit         filling;
      logic signed [KEY_BITS-1:0] kmin;
      logic signed [KEY_BITS-1:0] kmax;

      // every input known from time zero
      reset           = 1'b1;
      req_ch.valid    = 1'b0;
      req_ch.action   = '0;
      req_ch.position = '0;
      req_ch.key      = '0;
      req_ch.value    = '0;
      rsp_ch.ready    = 1'b0;

      kmin = {1'b1, {(KEY_BITS-1){1'b0}}};
      kmax = {1'b0, {(KEY_BITS-1){1'b1}}};
      for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      // directed: empty list corners first
      push_req(ACT_READ,   6'sd0, 0, 0);          // read from empty list
      push_req(ACT_REMOVE, 6'sd0, 0, 0);          // remove from empty list
      push_req(ACT_UPDATE, 6'sd0, 5, 9);          // key not stored
      push_req(ACT_INSERT, POS_APPEND, kmax, kmin);
      push_req(ACT_INSERT, 6'sd0, kmin, kmax);    // insert at the front
      push_req(ACT_INSERT, 6'sd31, 0, -1);        // large position appends
      push_req(ACT_INSERT, -6'sd2, 7, 7);         // negative but not append
      push_req(ACT_INSERT, -6'sd32, 7, 7);        // most negative position
      push_req(ACT_INSERT, 6'sd1, -1, 0);         // insert in the middle
      push_req(ACT_INSERT, 6'sd4, -1, 32'h1234);  // duplicate key at the end
      push_req(ACT_READ,   6'sd1, 0, 0);
      push_req(ACT_READ,   6'sd5, 0, 0);          // one past the end
      push_req(ACT_READ,   POS_APPEND, 0, 0);
      push_req(ACT_UPDATE, 6'sd0, -1, 32'h55aa);  // first of two matches only
      push_req(ACT_READ,   6'sd4, 0, 0);
      push_req(ACT_REMOVE, 6'sd2, 0, 0);
      push_req(ACT_REMOVE, POS_APPEND, 0, 0);
      // fill up, then hit the full list, with a bad position too
      while (gen_count < CAPACITY) push_req(ACT_INSERT, POS_APPEND, $urandom, $urandom);
      push_req(ACT_INSERT, 6'sd3, 1, 1);
      push_req(ACT_INSERT, -6'sd2, 1, 1);         // full wins over bad position
      push_req(ACT_READ,   6'sd15, 0, 0);
      push_req(ACT_REMOVE, 6'sd15, 0, 0);

      // random part: alternate phases that lean on insert and on remove
      filling = 1'b0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % PHASE_ITEMS == 0) filling = !filling;
         w = $urandom_range(0, 99);
         if (w < (filling ? 50 : 15))      act = ACT_INSERT;
         else if (w < 65)                  act = ACT_REMOVE;
         else if (w < 83)                  act = ACT_UPDATE;
         else                              act = ACT_READ;
         push_req(act, pick_pos(act),
                  ($urandom_range(0, 1) != 0) ? key_pool[$urandom_range(0, POOL_SIZE-1)]
                                              : pick_key(),
                  $urandom);
      end
      total_items = pending_reqs.size();
      tail_start  = total_items - TAIL_ITEMS;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // all requests in, then all responses out, then a few quiet cycles
      while (beats_in < total_items) @(posedge clock);
      while (list_outcomes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      fail_count += list_outcomes.size();

      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   // hard stop well past the slowest legal run
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // request side: note each accepted beat and predict its response
   always @(posedge clock) begin
      req_fire = !reset && req_ch.valid && req_ch.ready;
      if (req_fire) begin
         list_outcomes = {list_outcomes,
                          list_op_outcome(action_type'(req_ch.action),
                                          req_ch.position, req_ch.key,
                                          req_ch.value)};
         beats_in++;
      end
   end

   // request driver: a new beat once the last one is taken, with random idle bursts
   always @(negedge clock) begin
      list_req_type r;
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_fire) begin
         if (req_gap > 0) begin
            req_gap--;
            req_ch.valid <= 1'b0;
         end else if (pending_reqs.size() != 0 && beats_in < tail_start &&
                      $urandom_range(0, 7) == 0) begin
            // idle burst: drop valid and draw a random gap count
            req_gap = $urandom_range(0, 10);
            req_ch.valid <= 1'b0;
         end else if (pending_reqs.size() != 0) begin
            r = pending_reqs.pop_front();
            req_ch.action   <= r.act;
            req_ch.position <= r.pos;
            req_ch.key      <= r.key;
            req_ch.value    <= r.value;
            req_ch.valid    <= 1'b1;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // response ready: random stall bursts and one long hold to back up the block
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ch.ready <= 1'b0;
      end else if (!hold_done && beats_in >= PRESSURE_AT) begin
         // sender keeps offering while this runs, so the input stalls
         hold_done = 1'b1;
         hold_left = HOLD_CYCLES - 1;
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ch.ready <= 1'b0;
      end else if (beats_in < tail_start && $urandom_range(0, 7) == 0) begin
         rsp_stall = $urandom_range(0, 10);
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // response monitor: compare each beat with the oldest predicted outcome
   always @(posedge clock) begin
      list_outcome_type o;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (list_outcomes.size() == 0) begin
            if (fail_count < MAX_REPORTS)
               $display("unexpected response beat: status %0d key %h value %h count %0d",
                        rsp_ch.status, rsp_ch.key_out, rsp_ch.value_out, rsp_ch.count);
            fail_count++;
         end else begin
            o = list_outcomes.pop_front();
            if (rsp_ch.status !== o.status || rsp_ch.key_out !== o.key ||
                rsp_ch.value_out !== o.value || rsp_ch.count !== o.count) begin
               if (fail_count < MAX_REPORTS)
                  $display("mismatch: exp status %0d key %h value %h count %0d, got %0d %h %h %0d",
                           o.status, o.key, o.value, o.count, rsp_ch.status,
                           rsp_ch.key_out, rsp_ch.value_out, rsp_ch.count);
               fail_count++;
            end
         end
      end
   end

endmodule

// File: bounded_keyed_list_engine_unit.f
sv/bkle_pkg.sv
sv/bkle_req_if.sv
sv/bkle_rsp_if.sv
sv/bkle_controller.sv
sv/bkle_datapath.sv
sv/bounded_keyed_list_engine_unit.sv
sim/tb_bounded_keyed_list_engine_unit.sv
